/* rtl/core/utf8_stream_decoder_macros.svh */
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define UTF8_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked in the same cycle, outside reset.
`define UTF8_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/utf8sd_pkg.sv */
// Types, constants and helper functions for the UTF-8 stream decoder.
`timescale 1ns / 1ps
package utf8sd_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] LeadBad  = 8'hF8;

  localparam logic [CpWidth-1:0] Max1Byte  = 21'h00007F;
  localparam logic [CpWidth-1:0] Max2Byte  = 21'h0007FF;
  localparam logic [CpWidth-1:0] Max3Byte  = 21'h00FFFF;
  localparam logic [CpWidth-1:0] MaxPoint  = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLow   = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHigh  = 21'h00DFFF;
  localparam logic [CpWidth-1:0] ReplReset = 21'h00FFFD;

  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  // Results caused by one byte: plain errors, then an optional decoded
  // point, then the truncation errors of an end-of-string flush.
  typedef struct packed {
    logic [2:0]         err_count;
    logic [1:0]         trunc_count;
    logic               has_point;
    logic [CpWidth-1:0] point;
    logic [2:0]         point_len;
  } utf8sd_desc_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } utf8sd_qstat_t;

  function automatic logic seq_ok(input logic [2:0] len, input logic [CpWidth-1:0] v);
    logic ok;
    if (len == Len2) begin
      ok = (v > Max1Byte);
    end else if (len == Len3) begin
      ok = (v > Max2Byte) && !((v >= SurrLow) && (v <= SurrHigh));
    end else begin
      ok = (v > Max3Byte) && (v <= MaxPoint);
    end
    return ok;
  endfunction

endpackage

/* rtl/core/utf8_stream_decoder.sv */
// Top level of the streaming UTF-8 decoder.
// The first result of a byte passes through the descriptor queue and the output register.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready is high.
// The output register sends one result per cycle while out_ready is high; bursts of errors fill
// the descriptor queue and then hold off input. Synchronous reset empties the queue, closes any
// open sequence and sets the replacement point to 0xFFFD.
`timescale 1ns / 1ps
module utf8_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic        is_error,
  output logic        truncated,
  output logic [2:0]  bytes_used,
  output logic        last_of_run
);

  logic [utf8sd_pkg::CpWidth-1:0] repl_point;
  logic                           accept;
  logic                           push;
  logic                           pop;
  utf8sd_pkg::utf8sd_desc_t       front_desc;
  utf8sd_pkg::utf8sd_desc_t       head;
  utf8sd_pkg::utf8sd_qstat_t      qstat;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      repl_point <= utf8sd_pkg::ReplReset;
    end else if (cfg_we) begin
      repl_point <= cfg_wdata;
    end
  end

  utf8sd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .push          (push),
    .desc          (front_desc)
  );

  utf8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_desc),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  utf8sd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (qstat),
    .repl_point  (repl_point),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .is_error    (is_error),
    .truncated   (truncated),
    .bytes_used  (bytes_used),
    .last_of_run (last_of_run)
  );

endmodule

/* rtl/core/utf8sd_front.sv */
// Front end: classifies each accepted byte and tracks the open sequence.
`timescale 1ns / 1ps
module utf8sd_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     end_of_string,
  output logic                     push,
  output utf8sd_pkg::utf8sd_desc_t desc
);

  logic [2:0]                     exp_len;
  logic [2:0]                     exp_len_next;
  logic [2:0]                     held;
  logic [2:0]                     held_next;
  logic [utf8sd_pkg::CpWidth-1:0] partial;
  logic [utf8sd_pkg::CpWidth-1:0] partial_next;
  logic [utf8sd_pkg::CpWidth-1:0] extended;
  logic [2:0]                     held_inc;

  assign extended = {partial[utf8sd_pkg::CpWidth-7:0], data_byte[5:0]};
  assign held_inc = held + 3'd1;

  always_comb begin
    desc         = '0;
    exp_len_next = exp_len;
    held_next    = held;
    partial_next = partial;
    if ((data_byte & utf8sd_pkg::ContMask) == utf8sd_pkg::ContTag) begin
      if (exp_len == 3'd0) begin
        desc.err_count = 3'd1;
      end else begin
        partial_next = extended;
        held_next    = held_inc;
        if (held_inc >= exp_len) begin
          if (utf8sd_pkg::seq_ok(exp_len, extended)) begin
            desc.has_point = 1'b1;
            desc.point     = extended;
            desc.point_len = exp_len;
          end else begin
            desc.err_count = exp_len;
          end
          exp_len_next = 3'd0;
          held_next    = 3'd0;
          partial_next = '0;
        end
      end
    end else begin
      if (exp_len != 3'd0) begin
        desc.err_count = held;
      end
      exp_len_next = 3'd0;
      held_next    = 3'd0;
      partial_next = '0;
      if (data_byte < utf8sd_pkg::ContTag) begin
        desc.has_point = 1'b1;
        desc.point     = {13'd0, data_byte};
        desc.point_len = 3'd1;
      end else if (data_byte < utf8sd_pkg::Lead3) begin
        exp_len_next = utf8sd_pkg::Len2;
        held_next    = 3'd1;
        partial_next = {16'd0, data_byte[4:0]};
      end else if (data_byte < utf8sd_pkg::Lead4) begin
        exp_len_next = utf8sd_pkg::Len3;
        held_next    = 3'd1;
        partial_next = {17'd0, data_byte[3:0]};
      end else if (data_byte < utf8sd_pkg::LeadBad) begin
        exp_len_next = utf8sd_pkg::Len4;
        held_next    = 3'd1;
        partial_next = {18'd0, data_byte[2:0]};
      end else begin
        desc.err_count = desc.err_count + 3'd1;
      end
    end
    if (end_of_string && (exp_len_next != 3'd0)) begin
      desc.trunc_count = held_next[1:0];
      exp_len_next     = 3'd0;
      held_next        = 3'd0;
      partial_next     = '0;
    end
  end

  assign push = accept &&
                ((desc.err_count != 3'd0) || desc.has_point || (desc.trunc_count != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= 3'd0;
      held    <= 3'd0;
      partial <= '0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      held    <= held_next;
      partial <= partial_next;
    end
  end

endmodule

/* rtl/core/utf8sd_queue.sv */
// Short queue of result descriptors between the front and back ends.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"
module utf8sd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  utf8sd_pkg::utf8sd_desc_t  push_data,
  input  logic                      pop,
  output utf8sd_pkg::utf8sd_desc_t  head,
  output utf8sd_pkg::utf8sd_qstat_t stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  utf8sd_pkg::utf8sd_desc_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head           = entries[rd_ptr];
  assign stat.full      = (count == CntW'(DEPTH));
  assign stat.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `UTF8_ASSERT_IMPL(a_no_overflow, push, !stat.full || pop, "queue written while full")
  `UTF8_ASSERT_IMPL(a_no_underflow, pop, stat.not_empty, "queue read while empty")
  `UTF8_ASSERT_ALWAYS(a_count_bound, count <= CntW'(DEPTH), "queue count exceeds depth")

endmodule

/* rtl/core/utf8sd_back.sv */
// Back end: expands each descriptor into result transfers through an output register.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"
module utf8sd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  utf8sd_pkg::utf8sd_desc_t       head,
  input  utf8sd_pkg::utf8sd_qstat_t      stat,
  input  logic [utf8sd_pkg::CpWidth-1:0] repl_point,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utf8sd_pkg::CpWidth-1:0] code_point,
  output logic                           is_error,
  output logic                           truncated,
  output logic [2:0]                     bytes_used,
  output logic                           last_of_run
);

  logic [1:0]                     idx;
  logic [2:0]                     idx_ext;
  logic [2:0]                     total;
  logic                           load;
  logic                           last;
  logic [utf8sd_pkg::CpWidth-1:0] sel_point;
  logic                           sel_error;
  logic                           sel_trunc;
  logic [2:0]                     sel_used;

  assign idx_ext = {1'b0, idx};
  assign total   = head.err_count + {2'b00, head.has_point} + {1'b0, head.trunc_count};
  assign load    = stat.not_empty && (!out_valid || out_ready);
  assign last    = (idx_ext == (total - 3'd1));
  assign pop     = load && last;

  always_comb begin
    sel_point = repl_point;
    sel_error = 1'b1;
    sel_trunc = 1'b0;
    sel_used  = 3'd1;
    if (idx_ext < head.err_count) begin
      sel_trunc = 1'b0;
    end else if (head.has_point && (idx_ext == head.err_count)) begin
      sel_point = head.point;
      sel_error = 1'b0;
      sel_used  = head.point_len;
    end else begin
      sel_trunc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point  <= sel_point;
      is_error    <= sel_error;
      truncated   <= sel_trunc;
      bytes_used  <= sel_used;
      last_of_run <= last;
    end
  end

  `UTF8_ASSERT_IMPL(a_total_range, stat.not_empty, (total != 3'd0) && (total <= 3'd4), "descriptor result count out of range")
  `UTF8_ASSERT_IMPL(a_trunc_is_error, out_valid, !truncated || is_error, "truncation flag on a non-error result")
  `UTF8_ASSERT_IMPL(a_error_single_byte, out_valid && is_error, bytes_used == 3'd1, "error result consumed more than one byte")

endmodule

/* test/tb.sv */
// Self-checking testbench for the streaming UTF-8 decoder: directed table, then random byte streams.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [utf8sd_pkg::CpWidth-1:0] cp;
    logic                           err;
    logic                           trunc;
    logic [2:0]                     used;
    logic                           last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } stim_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    decoded_t   want;
  } probe_t;

  localparam decoded_t NoWant = '0;
  localparam int NumProbes = 24;
  localparam int PhaseBytes = 58;
  localparam int StallLimit = 2000;
  localparam int SettleCycles = 8;

  // Rows with typed results are checked against those values; the rest go through the decoder model.
  localparam probe_t Probes [NumProbes] = '{
    '{8'h00, 1'b0, 1'b1, '{21'h000000, 1'b0, 1'b0, 3'd1, 1'b1}},
    '{8'h7F, 1'b1, 1'b1, '{21'h00007F, 1'b0, 1'b0, 3'd1, 1'b1}},
    '{8'h80, 1'b0, 1'b1, '{21'h00FFFD, 1'b1, 1'b0, 3'd1, 1'b1}},
    '{8'hF8, 1'b0, 1'b1, '{21'h00FFFD, 1'b1, 1'b0, 3'd1, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, '{21'h00FFFD, 1'b1, 1'b0, 3'd1, 1'b1}},
    '{8'hC2, 1'b0, 1'b0, NoWant},
    '{8'hA9, 1'b0, 1'b0, NoWant},
    '{8'hF4, 1'b0, 1'b0, NoWant},
    '{8'h8F, 1'b0, 1'b0, NoWant},
    '{8'hBF, 1'b0, 1'b0, NoWant},
    '{8'hBF, 1'b0, 1'b0, NoWant},
    '{8'hEF, 1'b0, 1'b0, NoWant},
    '{8'hBF, 1'b0, 1'b0, NoWant},
    '{8'hBF, 1'b0, 1'b0, NoWant},
    '{8'hC0, 1'b0, 1'b0, NoWant},
    '{8'h80, 1'b0, 1'b0, NoWant},
    '{8'hED, 1'b0, 1'b0, NoWant},
    '{8'hA0, 1'b0, 1'b0, NoWant},
    '{8'h80, 1'b0, 1'b0, NoWant},
    '{8'hF0, 1'b0, 1'b0, NoWant},
    '{8'h9F, 1'b0, 1'b0, NoWant},
    '{8'h98, 1'b0, 1'b0, NoWant},
    '{8'h41, 1'b0, 1'b0, NoWant},
    '{8'hC3, 1'b1, 1'b1, '{21'h00FFFD, 1'b1, 1'b1, 3'd1, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [20:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [20:0] code_point;
  logic        is_error;
  logic        truncated;
  logic [2:0]  bytes_used;
  logic        last_of_run;

  logic [2:0]                     seq_len = '0;
  logic [2:0]                     seq_have = '0;
  logic [utf8sd_pkg::CpWidth-1:0] seq_bits = '0;
  logic [utf8sd_pkg::CpWidth-1:0] repl_point = utf8sd_pkg::ReplReset;

  decoded_t byte_results [$];
  decoded_t awaited_points [$];
  stim_t    byte_plan [$];
  decoded_t head;
  bit       steady = 1'b0;
  int       fails = 0;
  int       quiet_cycles = 0;

  utf8_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_point    (code_point),
    .is_error      (is_error),
    .truncated     (truncated),
    .bytes_used    (bytes_used),
    .last_of_run   (last_of_run)
  );

  always #6 clk = ~clk;

  function automatic logic point_legal(input logic [2:0] len,
                                       input logic [utf8sd_pkg::CpWidth-1:0] v);
    if (len == 3'd2) return v >= 21'h80;
    if (len == 3'd3) return v >= 21'h800 && v[20:11] != 10'h01B;
    return v >= 21'h10000 && v <= 21'h10FFFF;
  endfunction

  function automatic void add_result(input logic [utf8sd_pkg::CpWidth-1:0] cp, input logic err,
                                     input logic trunc, input logic [2:0] used);
    byte_results.push_back('{cp, err, trunc, used, 1'b0});
  endfunction

  function automatic void drop_held(input logic trunc);
    int i;
    for (i = 0; i < seq_have; i++) add_result(repl_point, 1'b1, trunc, 3'd1);
    seq_len = '0;
    seq_have = '0;
    seq_bits = '0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    byte_results.delete();
    if (b[7:6] == 2'b10) begin
      if (seq_len == 0) begin
        add_result(repl_point, 1'b1, 1'b0, 3'd1);
      end else begin
        seq_bits = {seq_bits[14:0], b[5:0]};
        seq_have = seq_have + 3'd1;
        if (seq_have >= seq_len) begin
          if (point_legal(seq_len, seq_bits)) begin
            add_result(seq_bits, 1'b0, 1'b0, seq_len);
            seq_len = '0;
            seq_have = '0;
            seq_bits = '0;
          end else begin
            drop_held(1'b0);
          end
        end
      end
    end else begin
      if (seq_len != 0) drop_held(1'b0);
      if (!b[7]) begin
        add_result({14'd0, b[6:0]}, 1'b0, 1'b0, 3'd1);
      end else if (b < 8'hE0) begin
        seq_len = 3'd2; seq_have = 3'd1; seq_bits = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        seq_len = 3'd3; seq_have = 3'd1; seq_bits = {17'd0, b[3:0]};
      end else if (b < 8'hF8) begin
        seq_len = 3'd4; seq_have = 3'd1; seq_bits = {18'd0, b[2:0]};
      end else begin
        add_result(repl_point, 1'b1, 1'b0, 3'd1);
      end
    end
    if (eos && seq_len != 0) drop_held(1'b1);
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].last = 1'b1;
  endfunction

  function automatic void record_transfer(input logic [7:0] b, input logic eos,
                                          input logic typed, input decoded_t want);
    decode_byte(b, eos);
    if (typed) awaited_points.push_back(want);
    else foreach (byte_results[i]) awaited_points.push_back(byte_results[i]);
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input int len, input int idx);
    logic [20:0] tail;
    tail = cp >> (6 * (len - 1 - idx));
    if (idx > 0) return {2'b10, tail[5:0]};
    case (len)
      1: return {1'b0, cp[6:0]};
      2: return {3'b110, cp[10:6]};
      3: return {4'b1110, cp[15:12]};
      default: return {5'b11110, cp[20:18]};
    endcase
  endfunction

  function automatic logic [20:0] legal_point(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp[20:11] == 10'h01B) cp = cp ^ 21'h2000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // Mostly well-formed sequences; the rest are overlong, surrogate, out of range, cut short or noise.
  task automatic plan_unit();
    int kind, len, keep, i;
    logic [20:0] cp;
    kind = $urandom_range(0, 99);
    len = $urandom_range(2, 4);
    keep = len;
    if (kind < 55) begin
      len = $urandom_range(1, 4);
      keep = len;
      cp = legal_point(len);
    end else if (kind < 65) begin
      cp = 21'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF));
    end else if (kind < 72) begin
      len = 3;
      keep = 3;
      cp = 21'($urandom_range('hD800, 'hDFFF));
    end else if (kind < 78) begin
      len = 4;
      keep = 4;
      cp = 21'($urandom_range('h110000, 'h1FFFFF));
    end else if (kind < 88) begin
      cp = legal_point(len);
      keep = $urandom_range(1, len - 1);
    end else begin
      keep = $urandom_range(1, 3);
    end
    for (i = 0; i < keep; i++) begin
      byte_plan.push_back('{kind < 88 ? utf8_byte(cp, len, i) : 8'($urandom_range(0, 255)),
                            $urandom_range(0, 99) < 3 ||
                            (i == keep - 1 && $urandom_range(0, 99) < 12)});
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_replacement(input logic [20:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_points.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    repl_point = v;
  endtask

  task automatic check_field(input string what, input logic [20:0] want, input logic [20:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      fails++;
    end
  endtask

  always @(negedge clk) out_ready <= steady || $urandom_range(0, 99) >= 28;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_points.size() == 0) begin
        $display("%0t: no result expected, got code_point %0h is_error %b", $time,
                 code_point, is_error);
        fails++;
      end else begin
        head = awaited_points.pop_front();
        check_field("code_point", head.cp, code_point);
        check_field("is_error", 21'(head.err), 21'(is_error));
        check_field("truncated", 21'(head.trunc), 21'(truncated));
        check_field("bytes_used", 21'(head.used), 21'(bytes_used));
        check_field("last_of_run", 21'(head.last), 21'(last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int row, ph, sent;
    stim_t s;
    logic [20:0] phase_repl [4];
    phase_repl[0] = 21'h000000;
    phase_repl[1] = 21'h10FFFF;
    phase_repl[2] = 21'($urandom_range(0, 'h10FFFF));
    phase_repl[3] = utf8sd_pkg::ReplReset;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    for (row = 0; row < NumProbes; row++) begin
      send_byte(Probes[row].b, Probes[row].eos);
      record_transfer(Probes[row].b, Probes[row].eos, Probes[row].typed, Probes[row].want);
    end
    for (ph = 0; ph < 4; ph++) begin
      set_replacement(phase_repl[ph]);
      steady = (ph == 1);
      sent = 0;
      while (sent < PhaseBytes) begin
        plan_unit();
        while (byte_plan.size() > 0) begin
          s = byte_plan.pop_front();
          send_byte(s.b, s.eos);
          record_transfer(s.b, s.eos, 1'b0, NoWant);
          sent++;
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/utf8sd_pkg.sv
rtl/core/utf8sd_front.sv
rtl/core/utf8sd_queue.sv
rtl/core/utf8sd_back.sv
rtl/core/utf8_stream_decoder.sv
test/tb.sv
